[hw/rtl/sse_pkg.sv]
// Package for the sample statistics engine: widths, state encoding, and the
// command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    // arithmetic widths, sized for the largest supported set (4096 samples)
    localparam int SMP_W     = 16;  // one sample
    localparam int NW        = 13;  // sample count as used in arithmetic
    localparam int SUM_W     = 29;  // signed running sum
    localparam int ABS_S_W   = 28;  // magnitude of the sum
    localparam int SS_W      = 56;  // sum squared
    localparam int P_W       = 30;  // n * x
    localparam int PX_W      = 46;  // n * x * x
    localparam int ACC_W     = 56;  // n * sum(x^2)
    localparam int D_W       = 31;  // n * x - sum
    localparam int DABS_W    = 30;  // |n * x - sum|
    localparam int ABSACC_W  = 42;  // sum of |n * x - sum|
    localparam int NN_W      = 26;  // n * n
    localparam int NN1_W     = 39;  // n * n * (n - 1)
    localparam int DVD_W     = 72;  // divider dividend and quotient
    localparam int DVS_W     = 40;  // divider divisor
    localparam int RT_W      = 24;  // square root result
    localparam int RES_W     = 24;  // Q16.8 result fields
    localparam int CNT_OUT_W = 7;   // reported sample count

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SETUP2,
        ST_MEAN_WAIT,
        ST_MED_RDI,
        ST_MED_LDI,
        ST_MED_SCAN,
        ST_MED_DRAIN,
        ST_MED_EVAL,
        ST_DEV_SCAN,
        ST_DEV_DRAIN,
        ST_MAD_DIV,
        ST_MAD_WAIT,
        ST_SD_DIV,
        ST_SD_WAIT,
        ST_SD_SQRT,
        ST_SD_SQWAIT,
        ST_SE_DIV,
        ST_SE_WAIT,
        ST_SE_SQRT,
        ST_SE_SQWAIT,
        ST_FINISH
    } sse_state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_MAD,
        DIV_SD,
        DIV_SE
    } sse_div_sel_t;

    typedef struct packed {
        logic         load_en;
        logic         set_clr;
        logic         setup;
        logic         setup2;
        logic         i_clr;
        logic         rd_i;
        logic         latch_v;
        logic         scan_clr;
        logic         scan_issue;
        logic         med_eval;
        logic         dev_clr;
        logic         dev_issue;
        logic         calc_t;
        logic         div_start;
        sse_div_sel_t div_sel;
        logic         div_latch;
        logic         sqrt_start;
        logic         latch_sd;
        logic         latch_se;
        logic         zero_se;
        logic         out_load;
    } sse_cmd_t;

    typedef struct packed {
        logic j_last;
        logic i_last;
        logic dev_busy;
        logic div_done;
        logic sqrt_done;
        logic single;
        logic out_free;
    } sse_status_t;

endpackage

`default_nettype wire

[hw/rtl/sse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sse_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sse_divider #(
    parameter int DVD_W = 72,
    parameter int DVS_W = 40
) (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W+1:0] diff;
    logic             fits;

    // trial subtraction of the divisor from the shifted remainder
    always_comb begin
        rem_sh = {rem_reg, quo_reg[DVD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        fits   = ~diff[DVS_W+1];
    end

    // step control
    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hw/rtl/sse_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sse_sqrt #(
    parameter int RT_W = 24
) (
    input  wire logic              clk,
    input  wire logic              rstn,
    input  wire logic              start,
    input  wire logic [2*RT_W-1:0] radicand,
    output logic                   done,
    output logic      [RT_W-1:0]   root
);

    localparam int CNT_W = $clog2(RT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [2*RT_W-1:0] rad_reg;
    logic [RT_W+1:0]   rem_reg;
    logic [RT_W-1:0]   root_reg;
    logic [RT_W+3:0]   rem_sh;
    logic [RT_W+3:0]   trial;
    logic [RT_W+4:0]   diff;
    logic              fits;

    // bring down two bits and try root*4+1
    always_comb begin
        rem_sh = {rem_reg, rad_reg[2*RT_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = {1'b0, rem_sh} - {1'b0, trial};
        fits   = ~diff[RT_W+4];
    end

    // step control
    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and root update
    always_ff @(posedge clk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[2*RT_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[RT_W+1:0] : rem_sh[RT_W+1:0];
            root_reg <= {root_reg[RT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

[hw/rtl/sse_datapath.sv]
// Datapath: sample store, running sum, rank counters for the median,
// deviation accumulators, divider, square root and result registers.
// Depends on sse_pkg, sse_ram, sse_divider and sse_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module sse_datapath #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rstn,
    input  wire sse_pkg::sse_cmd_t     cmd,
    output sse_pkg::sse_status_t       status,
    input  wire logic signed [15:0]    s_sample,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [23:0]         m_mean_value,
    output logic signed [23:0]         m_median_value,
    output logic        [23:0]         m_mean_abs_dev,
    output logic        [23:0]         m_std_dev,
    output logic        [23:0]         m_std_error,
    output logic        [6:0]          m_sample_count,
    output logic                       m_single_sample_error,
    output logic                       m_overflow_flag
);

    import sse_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    // set state
    logic [CW-1:0]           count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    dropped_reg;
    logic                    full;
    logic [CW-1:0]           cnt_m1;
    logic [NW-1:0]           n13;

    // memory ports
    logic [AW-1:0]           raddr;
    logic [SMP_W-1:0]        rdata;
    logic signed [SMP_W-1:0] rd_x;

    // setup products
    logic [ABS_S_W-1:0]      abs_s_reg;
    logic                    s_neg_reg;
    logic [SS_W-1:0]         ss_reg;
    logic [NN_W-1:0]         nn_reg;
    logic [NN1_W-1:0]        nn1_reg;
    logic [ABS_S_W-1:0]      abs_s;

    // median search
    logic [AW-1:0]           i_reg;
    logic [AW-1:0]           j_reg;
    logic signed [SMP_W-1:0] v_reg;
    logic                    cmp_vld_reg;
    logic [CW-1:0]           lt_reg;
    logic [CW-1:0]           le_reg;
    logic [CW-1:0]           k0;
    logic [CW-1:0]           k1;
    logic signed [SMP_W-1:0] med_lo_reg;
    logic signed [SMP_W-1:0] med_hi_reg;

    // deviation pipeline
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic signed [P_W-1:0]   p_reg;
    logic signed [SMP_W-1:0] x1_reg;
    logic signed [PX_W-1:0]  px_reg;
    logic [DABS_W-1:0]       dabs_reg;
    logic signed [D_W-1:0]   d_val;
    logic [ACC_W-1:0]        acc_reg;
    logic [ABSACC_W-1:0]     absacc_reg;
    logic [ACC_W-1:0]        t_reg;

    // divider, root and partial results
    logic [DVD_W-1:0]        dvd;
    logic [DVS_W-1:0]        dvs;
    logic                    div_done;
    logic [DVD_W-1:0]        quo;
    logic                    sqrt_done;
    logic [RT_W-1:0]         root;
    logic signed [RES_W-1:0] mean_reg;
    logic [RES_W-1:0]        mad_reg;
    logic [RES_W-1:0]        sd_reg;
    logic [RES_W-1:0]        se_reg;
    logic signed [SMP_W:0]   med_sum;

    // output registers
    logic                    m_valid_reg;
    logic signed [RES_W-1:0] o_mean_reg;
    logic signed [RES_W-1:0] o_median_reg;
    logic [RES_W-1:0]        o_mad_reg;
    logic [RES_W-1:0]        o_sd_reg;
    logic [RES_W-1:0]        o_se_reg;
    logic [CNT_OUT_W-1:0]    o_count_reg;
    logic                    o_single_reg;
    logic                    o_ovf_reg;

    assign full   = (count_reg == CW'(MAX_SAMPLES));
    assign cnt_m1 = count_reg - 1'b1;
    assign n13    = NW'(count_reg);
    assign k0     = cnt_m1 >> 1;
    assign k1     = count_reg >> 1;
    assign raddr  = cmd.rd_i ? i_reg : j_reg;
    assign rd_x   = signed'(rdata);
    assign abs_s  = sum_reg[SUM_W-1] ? ABS_S_W'(-sum_reg) : ABS_S_W'(sum_reg);

    sse_ram #(
        .WIDTH (SMP_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load_en && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // set accumulation and clearing after a result
    always_ff @(posedge clk) begin
        if (!rstn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.set_clr) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.load_en) begin
            if (full) begin
                dropped_reg <= 1'b1;
            end else begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SUM_W'(s_sample);
            end
        end
    end

    // scan indexes and rank counters
    always_ff @(posedge clk) begin
        if (!rstn) begin
            i_reg       <= '0;
            j_reg       <= '0;
            cmp_vld_reg <= 1'b0;
            lt_reg      <= '0;
            le_reg      <= '0;
        end else begin
            cmp_vld_reg <= cmd.scan_issue;
            if (cmd.i_clr) begin
                i_reg <= '0;
            end else if (cmd.med_eval) begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.scan_clr) begin
                j_reg  <= '0;
                lt_reg <= '0;
                le_reg <= '0;
            end else begin
                if (cmd.scan_issue || cmd.dev_issue) begin
                    j_reg <= j_reg + 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (rd_x < v_reg) begin
                        lt_reg <= lt_reg + 1'b1;
                    end
                    if (rd_x <= v_reg) begin
                        le_reg <= le_reg + 1'b1;
                    end
                end
            end
        end
    end

    // candidate value and the two middle order statistics
    always_ff @(posedge clk) begin
        if (cmd.latch_v) begin
            v_reg <= rd_x;
        end
        if (cmd.med_eval) begin
            if (lt_reg <= k0 && k0 < le_reg) begin
                med_lo_reg <= v_reg;
            end
            if (lt_reg <= k1 && k1 < le_reg) begin
                med_hi_reg <= v_reg;
            end
        end
    end

    // one-time products for the set
    always_ff @(posedge clk) begin
        if (cmd.setup) begin
            abs_s_reg <= abs_s;
            s_neg_reg <= sum_reg[SUM_W-1];
            ss_reg    <= SS_W'(abs_s) * SS_W'(abs_s);
            nn_reg    <= NN_W'(n13) * NN_W'(n13);
        end
        if (cmd.setup2) begin
            nn1_reg <= NN1_W'(nn_reg) * NN1_W'(n13 - 1'b1);
        end
        if (cmd.calc_t) begin
            t_reg <= acc_reg - ACC_W'(ss_reg);
        end
    end

    // deviation pipeline valid flags
    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.dev_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign d_val = D_W'(p_reg) - D_W'(sum_reg);

    // deviation pipeline: n*x, then n*x*x and |n*x - sum|, then accumulate
    always_ff @(posedge clk) begin
        if (v1_reg) begin
            p_reg  <= $signed({1'b0, n13}) * rd_x;
            x1_reg <= rd_x;
        end
        if (v2_reg) begin
            px_reg   <= p_reg * x1_reg;
            dabs_reg <= d_val[D_W-1] ? DABS_W'(-d_val) : DABS_W'(d_val);
        end
        if (cmd.dev_clr) begin
            acc_reg    <= '0;
            absacc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg    <= acc_reg + ACC_W'($unsigned(px_reg));
            absacc_reg <= absacc_reg + ABSACC_W'(dabs_reg);
        end
    end

    // divider operand selection
    always_comb begin
        unique case (cmd.div_sel)
            DIV_MEAN: begin
                dvd = DVD_W'({abs_s_reg, 8'h00});
                dvs = DVS_W'(n13);
            end
            DIV_MAD: begin
                dvd = DVD_W'({absacc_reg, 8'h00});
                dvs = DVS_W'(nn_reg);
            end
            DIV_SD: begin
                dvd = DVD_W'({t_reg, 16'h0000});
                dvs = DVS_W'(nn_reg);
            end
            DIV_SE: begin
                dvd = DVD_W'({t_reg, 16'h0000});
                dvs = DVS_W'(nn1_reg);
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    sse_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rstn     (rstn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    sse_sqrt #(
        .RT_W (RT_W)
    ) u_sqrt (
        .clk      (clk),
        .rstn     (rstn),
        .start    (cmd.sqrt_start),
        .radicand (quo[2*RT_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    // partial results
    always_ff @(posedge clk) begin
        if (cmd.div_latch) begin
            if (cmd.div_sel == DIV_MEAN) begin
                mean_reg <= s_neg_reg ? -signed'(quo[RES_W-1:0]) : signed'(quo[RES_W-1:0]);
            end else begin
                mad_reg <= quo[RES_W-1:0];
            end
        end
        if (cmd.latch_sd) begin
            sd_reg <= root;
        end
        if (cmd.zero_se) begin
            se_reg <= '0;
        end else if (cmd.latch_se) begin
            se_reg <= root;
        end
    end

    assign med_sum = (SMP_W+1)'(med_lo_reg) + (SMP_W+1)'(med_hi_reg);

    // result hand-off
    always_ff @(posedge clk) begin
        if (!rstn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.out_load) begin
            o_mean_reg   <= mean_reg;
            o_median_reg <= {med_sum, 7'b0000000};
            o_mad_reg    <= mad_reg;
            o_sd_reg     <= sd_reg;
            o_se_reg     <= se_reg;
            o_count_reg  <= CNT_OUT_W'(count_reg);
            o_single_reg <= (count_reg == CW'(1));
            o_ovf_reg    <= dropped_reg;
        end
    end

    // status back to the controller
    always_comb begin
        status.j_last    = (j_reg == cnt_m1[AW-1:0]);
        status.i_last    = (i_reg == cnt_m1[AW-1:0]);
        status.dev_busy  = v1_reg | v2_reg | v3_reg;
        status.div_done  = div_done;
        status.sqrt_done = sqrt_done;
        status.single    = (count_reg == CW'(1));
        status.out_free  = ~m_valid_reg | m_ready;
    end

    assign m_valid               = m_valid_reg;
    assign m_mean_value          = o_mean_reg;
    assign m_median_value        = o_median_reg;
    assign m_mean_abs_dev        = o_mad_reg;
    assign m_std_dev             = o_sd_reg;
    assign m_std_error           = o_se_reg;
    assign m_sample_count        = o_count_reg;
    assign m_single_sample_error = o_single_reg;
    assign m_overflow_flag       = o_ovf_reg;

endmodule

`default_nettype wire

[hw/rtl/sse_ctrl.sv]
// Controller state machine: sequences loading, median search, deviation
// pass, divisions and roots for one set. Depends on sse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rstn,
    input  wire logic                 s_valid,
    input  wire logic                 s_last,
    output logic                      s_ready,
    input  wire sse_pkg::sse_status_t status,
    output sse_pkg::sse_cmd_t         cmd
);

    import sse_pkg::*;

    sse_state_t state_reg;
    sse_state_t state_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_valid && s_last) state_next = ST_SETUP;
            ST_SETUP:     state_next = ST_SETUP2;
            ST_SETUP2:    state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (status.div_done) state_next = ST_MED_RDI;
            ST_MED_RDI:   state_next = ST_MED_LDI;
            ST_MED_LDI:   state_next = ST_MED_SCAN;
            ST_MED_SCAN:  if (status.j_last) state_next = ST_MED_DRAIN;
            ST_MED_DRAIN: state_next = ST_MED_EVAL;
            ST_MED_EVAL:  state_next = status.i_last ? ST_DEV_SCAN : ST_MED_RDI;
            ST_DEV_SCAN:  if (status.j_last) state_next = ST_DEV_DRAIN;
            ST_DEV_DRAIN: if (!status.dev_busy) state_next = ST_MAD_DIV;
            ST_MAD_DIV:   state_next = ST_MAD_WAIT;
            ST_MAD_WAIT:  if (status.div_done) state_next = ST_SD_DIV;
            ST_SD_DIV:    state_next = ST_SD_WAIT;
            ST_SD_WAIT:   if (status.div_done) state_next = ST_SD_SQRT;
            ST_SD_SQRT:   state_next = ST_SD_SQWAIT;
            ST_SD_SQWAIT: begin
                if (status.sqrt_done) begin
                    state_next = status.single ? ST_FINISH : ST_SE_DIV;
                end
            end
            ST_SE_DIV:    state_next = ST_SE_WAIT;
            ST_SE_WAIT:   if (status.div_done) state_next = ST_SE_SQRT;
            ST_SE_SQRT:   state_next = ST_SE_SQWAIT;
            ST_SE_SQWAIT: if (status.sqrt_done) state_next = ST_FINISH;
            ST_FINISH:    if (status.out_free) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready     = 1'b1;
                cmd.load_en = s_valid;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                cmd.i_clr = 1'b1;
            end
            ST_SETUP2: begin
                cmd.setup2    = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
            end
            ST_MEAN_WAIT: begin
                cmd.div_sel   = DIV_MEAN;
                cmd.div_latch = status.div_done;
            end
            ST_MED_RDI:   cmd.rd_i = 1'b1;
            ST_MED_LDI: begin
                cmd.latch_v  = 1'b1;
                cmd.scan_clr = 1'b1;
            end
            ST_MED_SCAN:  cmd.scan_issue = 1'b1;
            ST_MED_DRAIN: cmd = '0;
            ST_MED_EVAL: begin
                cmd.med_eval = 1'b1;
                cmd.scan_clr = status.i_last;
                cmd.dev_clr  = status.i_last;
            end
            ST_DEV_SCAN:  cmd.dev_issue = 1'b1;
            ST_DEV_DRAIN: cmd = '0;
            ST_MAD_DIV: begin
                cmd.calc_t    = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MAD;
            end
            ST_MAD_WAIT: begin
                cmd.div_sel   = DIV_MAD;
                cmd.div_latch = status.div_done;
            end
            ST_SD_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SD;
            end
            ST_SD_WAIT:   cmd.div_sel = DIV_SD;
            ST_SD_SQRT:   cmd.sqrt_start = 1'b1;
            ST_SD_SQWAIT: begin
                cmd.latch_sd = status.sqrt_done;
                cmd.zero_se  = status.sqrt_done && status.single;
            end
            ST_SE_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SE;
            end
            ST_SE_WAIT:   cmd.div_sel = DIV_SE;
            ST_SE_SQRT:   cmd.sqrt_start = 1'b1;
            ST_SE_SQWAIT: cmd.latch_se = status.sqrt_done;
            ST_FINISH: begin
                cmd.out_load = status.out_free;
                cmd.set_clr  = status.out_free;
            end
            default:      cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/sample_statistics_engine_core.sv]
// Loading: one sample item per cycle; ready stays high until the item marked last.
// After the last item of a set the engine computes the result: the median rank search
// reads the store once per pair of samples, and four divisions and two roots set the rest
// (one division and one root fewer for a single sample).
// The next set loads only after that; a finished result may wait in its output register.
// Reset (aresetn low, synchronous) empties the set and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module sample_statistics_engine_core #(
    parameter int MAX_SAMPLES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [23:0]      m_mean_value,
    output logic signed [23:0]      m_median_value,
    output logic        [23:0]      m_mean_abs_dev,
    output logic        [23:0]      m_std_dev,
    output logic        [23:0]      m_std_error,
    output logic        [6:0]       m_sample_count,
    output logic                    m_single_sample_error,
    output logic                    m_overflow_flag
);

    import sse_pkg::*;

    sse_cmd_t    cmd;
    sse_status_t status;

    sse_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sse_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk                   (aclk),
        .rstn                  (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .s_sample              (s_sample),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_mean_value          (m_mean_value),
        .m_median_value        (m_median_value),
        .m_mean_abs_dev        (m_mean_abs_dev),
        .m_std_dev             (m_std_dev),
        .m_std_error           (m_std_error),
        .m_sample_count        (m_sample_count),
        .m_single_sample_error (m_single_sample_error),
        .m_overflow_flag       (m_overflow_flag)
    );

endmodule

`default_nettype wire

[hw/rtl/sse_checker.sv]
// Port-level checks for the sample statistics engine, bound to the top level.
// Depends on sample_statistics_engine_core.
`timescale 1ns / 1ps
`default_nettype none

module sse_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_last,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [23:0] m_mean_value,
    input wire logic signed [23:0] m_median_value,
    input wire logic        [23:0] m_mean_abs_dev,
    input wire logic        [23:0] m_std_dev,
    input wire logic        [23:0] m_std_error,
    input wire logic        [6:0]  m_sample_count,
    input wire logic               m_single_sample_error
);

    // a stalled result holds its valid, mean, median and standard error
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_value)
            && $stable(m_median_value) && $stable(m_std_error))
        else $error("result changed while stalled");

    // a single-sample set has no spread and no standard error
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_single_sample_error |-> m_sample_count == 7'd1
            && m_std_error == 24'd0 && m_std_dev == 24'd0 && m_mean_abs_dev == 24'd0)
        else $error("single-sample result has nonzero spread");

    // the set closes on its last item
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("item taken right after last item");

endmodule

bind sample_statistics_engine_core sse_checker u_sse_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_valid               (s_valid),
    .s_ready               (s_ready),
    .s_last                (s_last),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_mean_value          (m_mean_value),
    .m_median_value        (m_median_value),
    .m_mean_abs_dev        (m_mean_abs_dev),
    .m_std_dev             (m_std_dev),
    .m_std_error           (m_std_error),
    .m_sample_count        (m_sample_count),
    .m_single_sample_error (m_single_sample_error)
);

`default_nettype wire
